// File: rtl/smac_pkg.sv
// Shared types, constants and codes of the shadow memory access checker.
package smac_pkg;

  localparam int unsigned GRANULE_BYTES = 8;
  localparam int unsigned GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int unsigned SH_DEPTH      = 65536;
  localparam int unsigned SH_AW         = $clog2(SH_DEPTH);
  localparam int unsigned SH_TOP        = SH_AW + GRAN_SHIFT;
  localparam int unsigned REC_DEPTH     = 1024;
  localparam int unsigned REC_AW        = $clog2(REC_DEPTH);
  localparam int unsigned CFG_AW        = 3;

  localparam logic [7:0] TAG_VALID     = 8'h00;
  localparam logic [7:0] TAG_LEFT      = 8'hf1;
  localparam logic [7:0] TAG_RIGHT     = 8'hf2;
  localparam logic [7:0] TAG_FREED     = 8'hf3;
  localparam logic [7:0] TAG_PAGE      = 8'hf4;
  localparam logic [7:0] TAG_UNTRACKED = 8'hff;

  // register index of the enable bit (word address bit 2)
  localparam logic CFG_REG_ENABLED = 1'b0;

  typedef enum logic [2:0] {
    CMD_CHECK_RD   = 3'd0,
    CMD_CHECK_WR   = 3'd1,
    CMD_ALLOC      = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_PAGE_ALLOC = 3'd4,
    CMD_PAGE_FREE  = 3'd5,
    CMD_POISON     = 3'd6,
    CMD_UNPOISON   = 3'd7
  } cmd_e;

  typedef enum logic [3:0] {
    FC_NONE        = 4'd0,
    FC_ADDR_OVF    = 4'd1,
    FC_UAF         = 4'd2,
    FC_REDZONE     = 4'd3,
    FC_TABLE_FULL  = 4'd4,
    FC_BAD_FREE    = 4'd5,
    FC_DOUBLE_FREE = 4'd6,
    FC_PAGE_OVF    = 4'd7,
    FC_HALTED      = 4'd8
  } fault_e;

  typedef enum logic [1:0] {
    REC_EMPTY  = 2'd0,
    REC_ACTIVE = 2'd1,
    REC_FREED  = 2'd2
  } rec_state_e;

  typedef struct packed {
    rec_state_e  state;
    logic [31:0] base;
    logic [31:0] user;
    logic [31:0] total;
    logic [31:0] usize;
    logic [7:0]  kind;
  } rec_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CHK_RD,
    ST_CHK_EV,
    ST_SCAN,
    ST_SCAN_END,
    ST_REC_EV,
    ST_FILL_LOAD,
    ST_FILL_SET,
    ST_FILL_RUN,
    ST_DONE
  } state_e;

endpackage

// File: rtl/smac_shadow_ram.sv
// Shadow tag memory: one port, registered read.
module smac_shadow_ram
  import smac_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SH_AW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [SH_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/smac_rec_ram.sv
// Allocation record memory: one port, registered read.
module smac_rec_ram
  import smac_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [REC_AW-1:0] addr_i,
  input  rec_t              wdata_i,
  output rec_t              rdata_o
);

  rec_t mem [REC_DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/shadow_memory_access_checker_unit.sv
// Top level: sequencer of the shadow memory access checker.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  in       | to block  | in_valid_i / in_stall_o | command, address, length, user_*,
//           |           |                         | kind, poison_tag
//  out      | from block| out_valid_o/out_stall_i | ok, fault_code, fault_address,
//           |           |                         | fault_length, fault_write
//  cfg      | to block  | APB psel/penable/pready | enabled (word 0)
//
// After reset a clearing pass sets every shadow tag to untracked and also empties
// all 1024 record entries; no beat is taken.
// One item at a time: a check reads then evaluates each shadow granule in turn
// on the single shadow port. Alloc and free walk the record table at one entry
// a cycle, then fill shadow tags at one granule a cycle; poison, unpoison and
// page commands fill shadow tags in the same way. Disabled or halted items skip
// the work and go straight to the result. A finished beat waits in the output
// register; the next item is taken meanwhile.
module shadow_memory_access_checker_unit
  import smac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        command_i,
  input  logic [31:0]       address_i,
  input  logic [31:0]       length_i,
  input  logic [31:0]       user_address_i,
  input  logic [31:0]       user_length_i,
  input  logic [7:0]        kind_i,
  input  logic [7:0]        poison_tag_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ok_o,
  output logic [3:0]        fault_code_o,
  output logic [31:0]       fault_address_o,
  output logic [31:0]       fault_length_o,
  output logic              fault_write_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned GL_W = 34 - GRAN_SHIFT;

  // control state
  state_e           state_q, state_d;
  logic [SH_AW-1:0] clr_q, clr_d;
  logic             halted_q, halted_d;
  logic             enabled_q;
  logic             out_valid_q, out_valid_d;

  // item
  cmd_e        cmd_q, cmd_d;
  logic [31:0] addr_q, addr_d, len_q, len_d, uaddr_q, uaddr_d, ulen_q, ulen_d;
  logic [7:0]  kind_q, kind_d, ptag_q, ptag_d;

  // pending result
  fault_e      res_code_q, res_code_d;
  logic [31:0] res_addr_q, res_addr_d, res_len_q, res_len_d;
  logic        res_wr_q, res_wr_d;

  // range check walker
  logic [SH_AW-1:0] chk_idx_q, chk_idx_d;
  logic [31:0]      cur_q, cur_d, end_q, end_d;

  // record scan
  logic [REC_AW:0]   cnt_q, cnt_d;
  logic              pv_q, pv_d;
  logic [REC_AW-1:0] pidx_q, pidx_d;
  logic              ha_v_q, ha_v_d, hb_v_q, hb_v_d, hc_v_q, hc_v_d;
  logic [REC_AW-1:0] ha_q, ha_d, hb_q, hb_d, hc_q, hc_d, slot_q, slot_d;

  // shadow fill unit
  logic [1:0]          job_q, job_d;
  logic [31:0]         f_addr_q, f_addr_d, f_size_q, f_size_d;
  logic [7:0]          f_tag_q, f_tag_d;
  logic                f_open_q, f_open_d;
  logic [SH_AW-1:0]    fcur_q, fcur_d;
  logic [SH_AW:0]      fend_q, fend_d;
  logic                part_en_q, part_en_d;
  logic [SH_AW-1:0]    part_idx_q, part_idx_d;
  logic [GRAN_SHIFT-1:0] part_val_q, part_val_d;

  // output register
  fault_e      o_code_q, o_code_d;
  logic [31:0] o_addr_q, o_addr_d, o_len_q, o_len_d;
  logic        o_wr_q, o_wr_d;

  // memories
  logic             sh_we;
  logic [SH_AW-1:0] sh_addr;
  logic [7:0]       sh_wdata, sh_rdata;
  logic              rec_we;
  logic [REC_AW-1:0] rec_addr;
  rec_t              rec_wdata, rec_rdata;

  // combinational helpers
  logic [32:0]     sum33;
  logic [31:0]     j_addr, j_size;
  logic [7:0]      j_tag;
  logic            j_open, j_last;
  logic [31:0]     gbase, gnext, segend, bad0, bad;
  logic [32:0]     ftop;
  logic [33:0]     ftop_r;
  logic [GL_W-1:0] glast;
  logic            in_acc, cfg_wr;

  smac_shadow_ram u_shadow (
    .clk_i   (clk_i),
    .we_i    (sh_we),
    .addr_i  (sh_addr),
    .wdata_i (sh_wdata),
    .rdata_o (sh_rdata)
  );

  smac_rec_ram u_rec (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .addr_i  (rec_addr),
    .wdata_i (rec_wdata),
    .rdata_o (rec_rdata)
  );

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == CFG_REG_ENABLED) ? {31'b0, enabled_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (cfg_wr && paddr[2] == CFG_REG_ENABLED) begin
      enabled_q <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------- datapath helpers
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign sum33      = {1'b0, addr_q} + {1'b0, len_q};

  // granule evaluation for the range check
  assign gbase  = 32'({chk_idx_q, {GRAN_SHIFT{1'b0}}});
  assign gnext  = gbase + 32'(GRANULE_BYTES);
  assign segend = (gnext > end_q) ? end_q : gnext;
  assign bad0   = gbase + 32'(sh_rdata);
  assign bad    = (bad0 < cur_q) ? cur_q : bad0;

  // fill bounds: granules [addr/G, ceil((addr+size)/G))
  assign ftop   = {1'b0, f_addr_q} + {1'b0, f_size_q};
  assign ftop_r = {1'b0, ftop} + 34'(GRANULE_BYTES - 1);
  assign glast  = ftop_r[33:GRAN_SHIFT];

  // fill jobs of each command, in order; open jobs write a partial tail tag
  always_comb begin
    j_addr = addr_q;
    j_size = len_q;
    j_tag  = TAG_VALID;
    j_open = 1'b0;
    j_last = 1'b1;
    case (cmd_q)
      CMD_ALLOC: begin
        j_last = (job_q == 2'd2);
        case (job_q)
          2'd0: j_tag = TAG_RIGHT;
          2'd1: begin
            j_tag  = TAG_LEFT;
            j_size = (uaddr_q > addr_q) ? (uaddr_q - addr_q) : 32'b0;
          end
          default: begin
            j_addr = uaddr_q;
            j_size = ulen_q;
            j_open = 1'b1;
          end
        endcase
      end
      CMD_FREE:      j_tag = TAG_FREED;
      CMD_PAGE_ALLOC: begin
        j_last = (job_q == 2'd1);
        if (job_q == 2'd0) begin
          j_tag = TAG_PAGE;
        end else begin
          j_size = (ulen_q > len_q) ? len_q : ulen_q;
          j_open = 1'b1;
        end
      end
      CMD_PAGE_FREE: j_tag = TAG_FREED;
      CMD_POISON:    j_tag = ptag_q;
      CMD_UNPOISON:  j_open = 1'b1;
      default:       j_open = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_d = cmd_q; addr_d = addr_q; len_d = len_q; uaddr_d = uaddr_q;
    ulen_d = ulen_q; kind_d = kind_q; ptag_d = ptag_q;
    res_code_d = res_code_q; res_addr_d = res_addr_q;
    res_len_d = res_len_q; res_wr_d = res_wr_q;
    chk_idx_d = chk_idx_q; cur_d = cur_q; end_d = end_q;
    cnt_d = cnt_q; pv_d = pv_q; pidx_d = pidx_q;
    ha_v_d = ha_v_q; hb_v_d = hb_v_q; hc_v_d = hc_v_q;
    ha_d = ha_q; hb_d = hb_q; hc_d = hc_q; slot_d = slot_q;
    job_d = job_q; f_addr_d = f_addr_q; f_size_d = f_size_q;
    f_tag_d = f_tag_q; f_open_d = f_open_q;
    fcur_d = fcur_q; fend_d = fend_q;
    part_en_d = part_en_q; part_idx_d = part_idx_q; part_val_d = part_val_q;
    o_code_d = o_code_q; o_addr_d = o_addr_q; o_len_d = o_len_q; o_wr_d = o_wr_q;
    sh_we     = 1'b0;
    sh_addr   = chk_idx_q;
    sh_wdata  = f_tag_q;
    rec_we    = 1'b0;
    rec_addr  = cnt_q[REC_AW-1:0];
    rec_wdata = rec_rdata;

    unique case (state_q)
      ST_CLEAR: begin
        sh_we    = 1'b1;
        sh_addr  = clr_q;
        sh_wdata = TAG_UNTRACKED;
        if (clr_q[SH_AW-1:REC_AW] == '0) begin
          rec_we    = 1'b1;
          rec_addr  = clr_q[REC_AW-1:0];
          rec_wdata = '0;
        end
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_e'(command_i);
          addr_d  = address_i;
          len_d   = length_i;
          uaddr_d = user_address_i;
          ulen_d  = user_length_i;
          kind_d  = kind_i;
          ptag_d  = poison_tag_i;
          res_code_d = FC_NONE;
          res_addr_d = 32'b0;
          res_len_d  = 32'b0;
          res_wr_d   = 1'b0;
          if (!enabled_q) begin
            state_d = ST_DONE;
          end else if (halted_q) begin
            res_code_d = FC_HALTED;
            state_d    = ST_DONE;
          end else begin
            state_d = ST_DISPATCH;
          end
        end
      end

      ST_DISPATCH: begin
        cnt_d  = '0;
        pv_d   = 1'b0;
        ha_v_d = 1'b0;
        hb_v_d = 1'b0;
        hc_v_d = 1'b0;
        job_d  = 2'd0;
        unique case (cmd_q) inside
          CMD_CHECK_RD, CMD_CHECK_WR: begin
            if (len_q == 32'b0) begin
              state_d = ST_DONE;
            end else if (sum33[32]) begin
              res_code_d = FC_ADDR_OVF;
              res_addr_d = addr_q;
              res_len_d  = len_q;
              res_wr_d   = cmd_q[0];
              state_d    = ST_DONE;
            end else if (addr_q[31:SH_TOP] != '0) begin
              state_d = ST_DONE;
            end else begin
              chk_idx_d = addr_q[SH_TOP-1:GRAN_SHIFT];
              cur_d     = addr_q;
              end_d     = sum33[31:0];
              state_d   = ST_CHK_RD;
            end
          end
          CMD_ALLOC: begin
            if (addr_q == 32'b0 || uaddr_q == 32'b0 || len_q == 32'b0) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          CMD_FREE: begin
            state_d = (uaddr_q == 32'b0) ? ST_DONE : ST_SCAN;
          end
          CMD_PAGE_ALLOC: begin
            if (addr_q == 32'b0 || len_q == 32'b0) begin
              state_d = ST_DONE;
            end else begin
              state_d = ST_FILL_LOAD;
            end
          end
          CMD_PAGE_FREE: begin
            if (addr_q == 32'b0 || len_q == 32'b0) begin
              state_d = ST_DONE;
            end else if (sum33[32]) begin
              res_code_d = FC_PAGE_OVF;
              res_addr_d = addr_q;
              res_len_d  = len_q;
              res_wr_d   = 1'b1;
              state_d    = ST_DONE;
            end else begin
              state_d = ST_FILL_LOAD;
            end
          end
          default: state_d = ST_FILL_LOAD;
        endcase
      end

      ST_CHK_RD: begin
        sh_addr = chk_idx_q;
        state_d = ST_CHK_EV;
      end

      ST_CHK_EV: begin
        if (sh_rdata == TAG_VALID || sh_rdata == TAG_UNTRACKED ||
            (sh_rdata < 8'(GRANULE_BYTES) && bad >= segend)) begin
          // granule clean over [cur, segend)
          if (segend >= end_q || chk_idx_q == '1) begin
            state_d = ST_DONE;
          end else begin
            cur_d     = segend;
            chk_idx_d = chk_idx_q + 1'b1;
            state_d   = ST_CHK_RD;
          end
        end else begin
          res_code_d = (sh_rdata == TAG_FREED) ? FC_UAF : FC_REDZONE;
          res_addr_d = (sh_rdata < 8'(GRANULE_BYTES)) ? bad : cur_q;
          res_len_d  = len_q;
          res_wr_d   = cmd_q[0];
          state_d    = ST_DONE;
        end
      end

      ST_SCAN: begin
        // read entry cnt, evaluate entry read last cycle
        if (!cnt_q[REC_AW]) begin
          rec_addr = cnt_q[REC_AW-1:0];
          pv_d     = 1'b1;
          pidx_d   = cnt_q[REC_AW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          if (cmd_q == CMD_ALLOC) begin
            if (rec_rdata.state == REC_FREED && rec_rdata.base == addr_q &&
                rec_rdata.kind == kind_q && !ha_v_q) begin
              ha_v_d = 1'b1;
              ha_d   = pidx_q;
            end
            if (rec_rdata.state == REC_EMPTY && !hb_v_q) begin
              hb_v_d = 1'b1;
              hb_d   = pidx_q;
            end
            if (rec_rdata.state == REC_FREED && !hc_v_q) begin
              hc_v_d = 1'b1;
              hc_d   = pidx_q;
            end
          end else if (rec_rdata.state != REC_EMPTY && rec_rdata.user == uaddr_q &&
                       rec_rdata.kind == kind_q) begin
            if (rec_rdata.state == REC_ACTIVE && !ha_v_q) begin
              ha_v_d = 1'b1;
              ha_d   = pidx_q;
            end
            if (rec_rdata.state == REC_FREED) begin
              hb_v_d = 1'b1;   // last freed match wins
              hb_d   = pidx_q;
            end
          end
        end
        if (cnt_q[REC_AW] && !pv_q) begin
          state_d = ST_SCAN_END;
        end
      end

      ST_SCAN_END: begin
        if (cmd_q == CMD_ALLOC) begin
          if (ha_v_q || hb_v_q || hc_v_q) begin
            rec_we   = 1'b1;
            rec_addr = ha_v_q ? ha_q : (hb_v_q ? hb_q : hc_q);
            rec_wdata.state = REC_ACTIVE;
            rec_wdata.base  = addr_q;
            rec_wdata.user  = uaddr_q;
            rec_wdata.total = len_q;
            rec_wdata.usize = ulen_q;
            rec_wdata.kind  = kind_q;
            state_d = ST_FILL_LOAD;
          end else begin
            res_code_d = FC_TABLE_FULL;
            res_addr_d = uaddr_q;
            res_len_d  = ulen_q;
            res_wr_d   = 1'b0;
            state_d    = ST_DONE;
          end
        end else begin
          if (ha_v_q || hb_v_q) begin
            rec_addr = ha_v_q ? ha_q : hb_q;
            slot_d   = ha_v_q ? ha_q : hb_q;
            state_d  = ST_REC_EV;
          end else begin
            res_code_d = FC_BAD_FREE;
            res_addr_d = uaddr_q;
            res_len_d  = 32'd1;
            res_wr_d   = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end

      ST_REC_EV: begin
        rec_addr = slot_q;
        if (rec_rdata.state == REC_ACTIVE) begin
          rec_we          = 1'b1;
          rec_wdata.state = REC_FREED;
          addr_d          = rec_rdata.base;
          len_d           = rec_rdata.total;
          state_d         = ST_FILL_LOAD;
        end else begin
          res_code_d = FC_DOUBLE_FREE;
          res_addr_d = uaddr_q;
          res_len_d  = rec_rdata.usize;
          res_wr_d   = 1'b1;
          state_d    = ST_DONE;
        end
      end

      ST_FILL_LOAD: begin
        f_addr_d = j_addr;
        f_size_d = j_size;
        f_tag_d  = j_tag;
        f_open_d = j_open;
        state_d  = ST_FILL_SET;
      end

      ST_FILL_SET: begin
        if (f_size_q == 32'b0 || f_addr_q[31:SH_TOP] != '0) begin
          if (j_last) begin
            state_d = ST_DONE;
          end else begin
            job_d   = job_q + 1'b1;
            state_d = ST_FILL_LOAD;
          end
        end else begin
          fcur_d = f_addr_q[SH_TOP-1:GRAN_SHIFT];
          fend_d = (glast > GL_W'(SH_DEPTH)) ? (SH_AW+1)'(SH_DEPTH) : glast[SH_AW:0];
          part_en_d  = f_open_q && (ftop[GRAN_SHIFT-1:0] != '0) && (ftop[32:SH_TOP] == '0);
          part_idx_d = ftop[SH_TOP-1:GRAN_SHIFT];
          part_val_d = ftop[GRAN_SHIFT-1:0];
          state_d    = ST_FILL_RUN;
        end
      end

      ST_FILL_RUN: begin
        sh_we   = 1'b1;
        sh_addr = fcur_q;
        sh_wdata = (part_en_q && fcur_q == part_idx_q) ? 8'(part_val_q) : f_tag_q;
        if (({1'b0, fcur_q} + 1'b1) == fend_q) begin
          if (j_last) begin
            state_d = ST_DONE;
          end else begin
            job_d   = job_q + 1'b1;
            state_d = ST_FILL_LOAD;
          end
        end else begin
          fcur_d = fcur_q + 1'b1;
        end
      end

      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_code_d    = res_code_q;
          o_addr_d    = res_addr_q;
          o_len_d     = res_len_q;
          o_wr_d      = res_wr_q;
          halted_d    = halted_q | (res_code_q != FC_NONE);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; addr_q <= addr_d; len_q <= len_d; uaddr_q <= uaddr_d;
    ulen_q <= ulen_d; kind_q <= kind_d; ptag_q <= ptag_d;
    res_code_q <= res_code_d; res_addr_q <= res_addr_d;
    res_len_q <= res_len_d; res_wr_q <= res_wr_d;
    chk_idx_q <= chk_idx_d; cur_q <= cur_d; end_q <= end_d;
    cnt_q <= cnt_d; pv_q <= pv_d; pidx_q <= pidx_d;
    ha_v_q <= ha_v_d; hb_v_q <= hb_v_d; hc_v_q <= hc_v_d;
    ha_q <= ha_d; hb_q <= hb_d; hc_q <= hc_d; slot_q <= slot_d;
    job_q <= job_d; f_addr_q <= f_addr_d; f_size_q <= f_size_d;
    f_tag_q <= f_tag_d; f_open_q <= f_open_d;
    fcur_q <= fcur_d; fend_q <= fend_d;
    part_en_q <= part_en_d; part_idx_q <= part_idx_d; part_val_q <= part_val_d;
    o_code_q <= o_code_d; o_addr_q <= o_addr_d; o_len_q <= o_len_d; o_wr_q <= o_wr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = (o_code_q == FC_NONE);
  assign fault_code_o    = o_code_q;
  assign fault_address_o = o_addr_q;
  assign fault_length_o  = o_len_q;
  assign fault_write_o   = o_wr_q;

  // ---------------------------------------------------------------- assertions
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_pass_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> fault_address_o == 32'b0 && fault_length_o == 32'b0 &&
                            !fault_write_o)
    else $error("passing beat carries fault data");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted state cleared without reset");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL_RUN |-> {1'b0, fcur_q} < fend_q)
    else $error("fill pointer past end of range");

  a_halted_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_code_o == FC_HALTED |-> halted_q)
    else $error("halted code reported while not halted");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the shadow memory access checker: predicted verdict per beat.
`timescale 1ns / 100ps

module testbench;
  import smac_pkg::*;

  // ---------------------------------------------------------------------------
  // Beat payloads as seen by the predictor
  // ---------------------------------------------------------------------------
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] uaddr;
    logic [31:0] ulen;
    logic [7:0]  kind;
    logic [7:0]  ptag;
  } access_t;

  typedef struct packed {
    logic        ok;
    fault_e      code;
    logic [31:0] faddr;
    logic [31:0] flen;
    logic        fwr;
  } verdict_t;

  // heap object the stimulus keeps track of, so frees and reuse stay legal
  typedef struct {
    logic [31:0] base;
    logic [31:0] total;
    logic [31:0] user;
    logic [31:0] usize;
    logic [7:0]  kind;
  } heap_obj_t;

  localparam logic [CFG_AW-1:0] ENABLE_ADDR = {CFG_REG_ENABLED, 2'b00};
  localparam logic [63:0]       ADDR_MAX    = 64'hffff_ffff;
  localparam logic [63:0]       GB          = GRANULE_BYTES;

  // ---------------------------------------------------------------------------
  // Shadow model: tag per granule, record table, enable and halted flag.
  // predict() with commit=0 is a dry run used to keep random stimulus clean.
  // ---------------------------------------------------------------------------
  class shadow_scoreboard;
    logic [7:0] tags [SH_DEPTH];
    rec_t       recs [REC_DEPTH];
    bit         en;
    bit         halt;
    verdict_t   due [$];
    int         errors;

    function new();
      foreach (tags[i]) tags[i] = TAG_UNTRACKED;
      foreach (recs[i]) recs[i] = '0;
      en = 0;
      halt = 0;
      errors = 0;
    endfunction

    function void fill(logic [63:0] a, logic [63:0] sz, logic [7:0] t, bit commit);
      logic [63:0] first, last;
      if (sz == 0 || !commit) return;
      first = a / GB;
      last  = (a + sz + GB - 1) / GB;
      if (first >= SH_DEPTH) return;
      if (last > SH_DEPTH) last = SH_DEPTH;
      for (int unsigned g = first; g < last; g++) tags[g] = t;
    endfunction

    // valid bytes, with a partial count in the tail granule
    function void open(logic [63:0] a, logic [63:0] sz, bit commit);
      logic [63:0] top, rest;
      fill(a, sz, TAG_VALID, commit);
      if (sz == 0 || !commit) return;
      top  = a + sz;
      rest = top % GB;
      if (rest != 0 && top / GB < SH_DEPTH) tags[top / GB] = rest[7:0];
    endfunction

    function verdict_t flag(fault_e c, logic [63:0] a, logic [63:0] l, logic w);
      verdict_t v;
      v.ok = 0; v.code = c; v.faddr = a[31:0]; v.flen = l[31:0]; v.fwr = w;
      return v;
    endfunction

    function verdict_t predict(access_t it, bit commit);
      verdict_t    v;
      logic [63:0] a, l, stop, cur, gi, seg, bad, req, rz;
      logic [7:0]  t;
      int          slot;
      v = '{ok: 1'b1, code: FC_NONE, faddr: '0, flen: '0, fwr: 1'b0};
      if (!en) return v;
      if (halt) begin
        v.ok = 0;
        v.code = FC_HALTED;
        return v;
      end
      a = it.addr;
      l = it.len;
      slot = -1;
      case (it.cmd)
        CMD_CHECK_RD, CMD_CHECK_WR: begin
          stop = a + l;
          if (l == 0) begin
          end else if (stop > ADDR_MAX) begin
            v = flag(FC_ADDR_OVF, a, l, it.cmd[0]);
          end else begin
            cur = a;
            while (cur < stop) begin
              gi = cur / GB;
              if (gi >= SH_DEPTH) break;
              seg = (gi + 1) * GB;
              if (seg > stop) seg = stop;
              t = tags[gi];
              if (t == TAG_VALID || t == TAG_UNTRACKED) begin
                cur = seg;
                continue;
              end
              if (t < GB) begin
                // partial granule: first invalid byte at the tag count
                bad = gi * GB + t;
                if (bad < cur) bad = cur;
                if (bad >= seg) begin
                  cur = seg;
                  continue;
                end
                cur = bad;
              end
              v = flag(t == TAG_FREED ? FC_UAF : FC_REDZONE, cur, l, it.cmd[0]);
              break;
            end
          end
        end
        CMD_ALLOC: begin
          if (it.addr != 0 && it.uaddr != 0 && it.len != 0) begin
            // reuse a freed record of same base and kind, else empty, else any freed
            for (int i = 0; i < REC_DEPTH && slot < 0; i++)
              if (recs[i].state == REC_FREED && recs[i].base == it.addr &&
                  recs[i].kind == it.kind) slot = i;
            for (int i = 0; i < REC_DEPTH && slot < 0; i++)
              if (recs[i].state == REC_EMPTY) slot = i;
            for (int i = 0; i < REC_DEPTH && slot < 0; i++)
              if (recs[i].state == REC_FREED) slot = i;
            if (slot < 0) begin
              v = flag(FC_TABLE_FULL, it.uaddr, it.ulen, 1'b0);
            end else if (commit) begin
              recs[slot] = '{state: REC_ACTIVE, base: it.addr, user: it.uaddr,
                             total: it.len, usize: it.ulen, kind: it.kind};
              fill(a, l, TAG_RIGHT, 1);
              if (it.uaddr > it.addr) fill(a, 64'(it.uaddr - it.addr), TAG_LEFT, 1);
              open(it.uaddr, it.ulen, 1);
            end
          end
        end
        CMD_FREE: begin
          if (it.uaddr != 0) begin
            // an active match wins over any freed one
            for (int i = 0; i < REC_DEPTH; i++) begin
              if (recs[i].state == REC_EMPTY || recs[i].user != it.uaddr ||
                  recs[i].kind != it.kind) continue;
              slot = i;
              if (recs[i].state == REC_ACTIVE) break;
            end
            if (slot < 0) begin
              v = flag(FC_BAD_FREE, it.uaddr, 1, 1'b1);
            end else if (recs[slot].state != REC_ACTIVE) begin
              v = flag(FC_DOUBLE_FREE, it.uaddr, recs[slot].usize, 1'b1);
            end else if (commit) begin
              fill(recs[slot].base, recs[slot].total, TAG_FREED, 1);
              recs[slot].state = REC_FREED;
            end
          end
        end
        CMD_PAGE_ALLOC: begin
          if (a != 0 && l != 0) begin
            req = it.ulen;
            if (req > l) req = l;
            fill(a, l, TAG_PAGE, commit);
            open(a, req, commit);
            rz = ((a + req + GB - 1) / GB) * GB;
            if (rz < a + l) fill(rz, a + l - rz, TAG_PAGE, commit);
          end
        end
        CMD_PAGE_FREE: begin
          if (a != 0 && l != 0) begin
            if (a + l > ADDR_MAX) v = flag(FC_PAGE_OVF, a, l, 1'b1);
            else fill(a, l, TAG_FREED, commit);
          end
        end
        CMD_POISON: fill(a, l, it.ptag, commit);
        default:    open(a, l, commit);
      endcase
      if (commit && !v.ok) halt = 1;
      return v;
    endfunction

    function void note(access_t it);
      due.push_back(predict(it, 1));
    endfunction

    function void check(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing pending: %p", got);
        return;
      end
      want = due.pop_front();
      if (got.ok !== want.ok || got.code !== want.code || got.faddr !== want.faddr ||
          got.flen !== want.flen || got.fwr !== want.fwr) begin
        errors++;
        if (errors <= 10)
          $display("verdict mismatch: expected ok=%0b code=%0d addr=%h len=%h wr=%0b, got ok=%0b code=%0d addr=%h len=%h wr=%0b",
                   want.ok, want.code, want.faddr, want.flen, want.fwr,
                   got.ok, got.code, got.faddr, got.flen, got.fwr);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic              clk_i, rst_ni;
  logic              in_valid_i, in_stall_o;
  logic [2:0]        command_i;
  logic [31:0]       address_i, length_i, user_address_i, user_length_i;
  logic [7:0]        kind_i, poison_tag_i;
  logic              out_valid_o, out_stall_i;
  logic              ok_o;
  logic [3:0]        fault_code_o;
  logic [31:0]       fault_address_o, fault_length_o;
  logic              fault_write_o;
  logic              psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata, prdata;

  shadow_memory_access_checker_unit u_dut (.*);

  shadow_scoreboard sb;
  heap_obj_t        live_objs [$];
  heap_obj_t        freed_objs [$];
  int               beats_sent;
  int               beats_seen;
  bit               burst;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Global watchdog; sized for the clearing pass, whole-shadow walks and
  // ~1000 beats with table walks, several times over.
  initial begin
    #(60_000_000);
    $display("shadow_memory_access_checker_unit regression: fail");
    $finish;
  end

  // Result monitor: a beat moves when valid is high and we are not stalling.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check('{ok: ok_o, code: fault_e'(fault_code_o), faddr: fault_address_o,
                 flen: fault_length_o, fwr: fault_write_o});
      beats_seen++;
    end
  end

  // Receiver: random hold-off per beat, none in burst windows, and one long
  // hold-off so the block backs up and stalls its input.
  initial begin
    int n;
    bit held;
    held = 0;
    out_stall_i <= 1'b1;
    wait (rst_ni);
    forever begin
      n = burst ? 0 : $urandom_range(0, 6);
      if (!held && beats_seen >= 400) begin
        n = 300;
        held = 1;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic apb_write(logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ENABLE_ADDR; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // access edge: register takes the write here
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.en = data[0];
  endtask

  task automatic apb_read_check();
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ENABLE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[0] !== sb.en) begin
      sb.errors++;
      if (sb.errors <= 10) $display("enable readback: expected %0b got %0b", sb.en, prdata[0]);
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Offer one beat after a random gap; returns at the edge it was taken.
  task automatic offer(access_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= it.cmd;
    address_i      <= it.addr;
    length_i       <= it.len;
    user_address_i <= it.uaddr;
    user_length_i  <= it.ulen;
    kind_i         <= it.kind;
    poison_tag_i   <= it.ptag;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(it);
    beats_sent++;
    burst = ((beats_sent / 64) % 4) == 3;
  endtask

  // Drain: nothing pending, then an idle pause so a config write sees an idle block.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic access_t mk(cmd_e c, logic [31:0] a, logic [31:0] l,
                                 logic [31:0] ua = 0, logic [31:0] ul = 0,
                                 logic [7:0] k = 0, logic [7:0] pt = 0);
    access_t it;
    it = '{cmd: c, addr: a, len: l, uaddr: ua, ulen: ul, kind: k, ptag: pt};
    return it;
  endfunction

  function automatic access_t noise();
    return mk(cmd_e'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom);
  endfunction

  // Mostly legal traffic in a small heap window plus untracked far space;
  // anything the dry run says would fault is redrawn so the run stays live.
  function automatic access_t legal_beat();
    access_t   it;
    heap_obj_t o;
    int        pick, idx, off, tries;
    bit        is_alloc, is_free;
    for (tries = 0; tries < 40; tries++) begin
      pick = $urandom_range(0, 99);
      is_alloc = 0;
      is_free = 0;
      idx = 0;
      if (pick < 25) begin
        it = mk(cmd_e'($urandom_range(0, 1)), $urandom_range(0, 32'h1000),
                $urandom_range(1, 24));
      end else if (pick < 35 && live_objs.size() != 0) begin
        // access inside a live object's user bytes
        o = live_objs[$urandom_range(0, live_objs.size() - 1)];
        off = $urandom_range(0, 7);
        it = mk(cmd_e'($urandom_range(0, 1)), o.user + off, $urandom_range(1, 8));
      end else if (pick < 45) begin
        it.addr = $urandom_range(32'h0010_0000, 32'hffff_fff0);
        it = mk(cmd_e'($urandom_range(0, 1)), it.addr,
                $urandom_range(1, 32'hffff_ffff - it.addr));
      end else if (pick < 55) begin
        o.base  = 32'h40 * $urandom_range(1, 63);
        o.total = $urandom_range(16, 64);
        off     = $urandom_range(0, 15);
        o.user  = o.base + off;
        o.usize = $urandom_range(0, o.total - off);
        o.kind  = $urandom;
        if (freed_objs.size() != 0 && $urandom_range(0, 2) == 0) begin
          o.base = freed_objs[0].base;
          o.kind = freed_objs[0].kind;
          o.user = o.base + off;
        end
        it = mk(CMD_ALLOC, o.base, o.total, o.user, o.usize, o.kind);
        is_alloc = 1;
      end else if (pick < 60) begin
        // far heap: all shadow writes fall outside the tracked space
        o.base  = $urandom_range(32'h0010_0000, 32'hf000_0000);
        o.total = $urandom | 32'h1;
        o.user  = $urandom | 32'h0010_0000;
        o.usize = $urandom;
        o.kind  = $urandom;
        it = mk(CMD_ALLOC, o.base, o.total, o.user, o.usize, o.kind);
        is_alloc = 1;
      end else if (pick < 70 && live_objs.size() != 0) begin
        idx = $urandom_range(0, live_objs.size() - 1);
        o = live_objs[idx];
        it = mk(CMD_FREE, $urandom, $urandom, o.user, $urandom, o.kind);
        is_free = 1;
      end else if (pick < 76) begin
        it = mk(CMD_POISON, $urandom_range(0, 32'h1000), $urandom_range(1, 32), 0, 0, 0,
                $urandom);
      end else if (pick < 82) begin
        it = mk(CMD_UNPOISON, $urandom_range(0, 32'h1000), $urandom_range(1, 40));
      end else if (pick < 87) begin
        it = mk(CMD_PAGE_ALLOC, $urandom_range(1, 32'h1000), $urandom_range(1, 64), $urandom,
                $urandom_range(0, 80), $urandom);
      end else if (pick < 90) begin
        it = mk(CMD_PAGE_FREE, $urandom_range(1, 32'h1000), $urandom_range(1, 24));
      end else begin
        it = noise();
      end
      if (sb.predict(it, 0).ok) begin
        if (is_alloc) live_objs.push_back(o);
        if (is_free) begin
          live_objs.delete(idx);
          freed_objs.push_front(o);
          if (freed_objs.size() > 8) void'(freed_objs.pop_back());
        end
        return it;
      end
    end
    return mk(CMD_CHECK_RD, 32'h0100_0000, 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int which;
    sb = new();
    beats_sent = 0;
    beats_seen = 0;
    burst = 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    command_i <= CMD_CHECK_RD;
    address_i <= '0; length_i <= '0; user_address_i <= '0; user_length_i <= '0;
    kind_i <= '0; poison_tag_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled: every beat passes, even ones that would fault
    apb_write(32'h0);
    apb_read_check();
    offer(mk(CMD_CHECK_WR, 32'hffff_fff0, 32'h20));
    offer(mk(CMD_FREE, 0, 0, 32'h5, 0, 8'h11));
    repeat (3) offer(noise());
    drain();

    apb_write(32'h1);
    apb_read_check();

    // directed: whole-shadow walk while still untracked, then open it all up
    offer(mk(CMD_CHECK_RD, 32'h0, 32'h8_0000));
    offer(mk(CMD_UNPOISON, 32'h0, 32'h9_0000));
    offer(mk(CMD_CHECK_RD, 32'hffff_ffff, 32'h0));                 // zero length
    offer(mk(CMD_POISON, 32'h10, 32'h0, 0, 0, 0, TAG_FREED));       // zero length
    offer(mk(CMD_ALLOC, 32'h0, 32'h40, 32'h10, 8, 8'h1));           // null base
    offer(mk(CMD_ALLOC, 32'h100, 32'h40, 32'h0, 8, 8'h1));          // null user
    offer(mk(CMD_ALLOC, 32'h100, 32'h0, 32'h110, 8, 8'h1));         // null size
    offer(mk(CMD_FREE, 32'h0, 32'h0, 32'h0, 0, 8'h0));              // null free
    offer(mk(CMD_PAGE_ALLOC, 32'h0, 32'h40, 0, 8, 8'h0));           // null page
    offer(mk(CMD_PAGE_FREE, 32'h1900, 32'h0));                      // null page size
    // object with redzones and a partial tail granule, then an in-bounds access
    offer(mk(CMD_ALLOC, 32'h100, 32'h40, 32'h110, 13, 8'hff));
    live_objs.push_back('{base: 32'h100, total: 32'h40, user: 32'h110, usize: 13,
                          kind: 8'hff});
    offer(mk(CMD_CHECK_RD, 32'h110, 32'd13));
    offer(mk(CMD_PAGE_ALLOC, 32'h1800, 32'h40, 32'h0, 32'd20, 8'h0));
    offer(mk(CMD_CHECK_WR, 32'h1800, 32'd20));
    offer(mk(CMD_POISON, 32'h1c00, 32'd9, 0, 0, 0, TAG_VALID));
    offer(mk(CMD_UNPOISON, 32'h1c00, 32'd5));
    offer(mk(CMD_POISON, 32'h7fff8, 32'h100, 0, 0, 0, TAG_PAGE));   // clipped at shadow end
    offer(mk(CMD_POISON, 32'hffff_ff00, 32'hff, 0, 0, 0, 8'hff));   // starts beyond shadow
    offer(mk(CMD_PAGE_FREE, 32'h1900, 32'd8));
    offer(mk(CMD_CHECK_WR, 32'h0010_0000, 32'hffef_ffff));          // ends just below the top byte

    repeat (1000) offer(legal_beat());
    drain();

    // one deliberate fault, then the block stays halted
    which = $urandom_range(0, 5);
    case (which)
      0: offer(mk(CMD_CHECK_RD, 32'hffff_fff0, 32'h20));
      1: begin
        offer(mk(CMD_PAGE_FREE, 32'h7_0000, 32'd64));
        offer(mk(CMD_CHECK_RD, 32'h7_0008, 32'd4));
      end
      2: begin
        offer(mk(CMD_POISON, 32'h7_1000, 32'd16, 0, 0, 0, TAG_LEFT));
        offer(mk(CMD_CHECK_WR, 32'h7_1004, 32'd8));
      end
      3: offer(mk(CMD_FREE, 0, 0, 32'h0007_7777, 0, 8'h5a));
      4: begin
        offer(mk(CMD_ALLOC, 32'h0200_0000, 32'd64, 32'h0200_0010, 32'd8, 8'h3c));
        offer(mk(CMD_FREE, 0, 0, 32'h0200_0010, 0, 8'h3c));
        offer(mk(CMD_FREE, 0, 0, 32'h0200_0010, 0, 8'h3c));
      end
      default: offer(mk(CMD_PAGE_FREE, 32'hffff_ff00, 32'h200));
    endcase
    repeat (4) offer(noise());
    drain();

    // disabled overrides halted; re-enabled it is halted again
    apb_write(32'h0);
    repeat (3) offer(noise());
    drain();
    apb_write(32'hffff_ffff);
    apb_read_check();
    repeat (2) offer(noise());
    drain();

    if (sb.errors == 0) begin
      $display("shadow_memory_access_checker_unit regression: pass");
    end else begin
      $display("shadow_memory_access_checker_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/smac_pkg.sv
rtl/smac_shadow_ram.sv
rtl/smac_rec_ram.sv
rtl/shadow_memory_access_checker_unit.sv
bench/testbench.sv
